### rtl/core/wsu_pkg.sv
package wsu_pkg;

    localparam int unsigned CFG_W    = 32;
    localparam int unsigned LEN_W    = 64;
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned FCNT_W   = 4;

    // queue depth must stay a power of two, pointers wrap on their own
    localparam int unsigned Q_DEPTH  = 4;
    localparam int unsigned Q_AW     = 2;

    localparam logic [CFG_W-1:0]  MAX_PAYLOAD_RST = 32'd4086;
    localparam logic [6:0]        LEN_CODE_16     = 7'd126;
    localparam logic [6:0]        LEN_CODE_64     = 7'd127;
    localparam logic [FCNT_W-1:0] EXT16_BYTES     = 4'd2;
    localparam logic [FCNT_W-1:0] EXT64_BYTES     = 4'd8;
    localparam logic [FCNT_W-1:0] KEY_BYTES       = 4'd4;

    typedef enum logic [1:0] {
        KIND_HDR = 2'd0,
        KIND_EXT = 2'd1,
        KIND_KEY = 2'd2,
        KIND_PAY = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        PH_HDR0 = 5'b00001,
        PH_HDR1 = 5'b00010,
        PH_EXT  = 5'b00100,
        PH_KEY  = 5'b01000,
        PH_PAY  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] key;
        t_kind      kind;
        logic [3:0] opcode;
        logic       fin;
        logic       last;
        logic       over;
    } t_cmd;

endpackage

### rtl/core/wsu_front.sv
module wsu_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_byte,
    input  logic                        i_cfg_valid,
    input  logic [wsu_pkg::CFG_W-1:0]   i_cfg_data,
    output logic                        o_cmd_valid,
    input  logic                        i_cmd_ready,
    output wsu_pkg::t_cmd               o_cmd
);

    wsu_pkg::t_phase                 r_phase, n_phase;
    logic [wsu_pkg::FCNT_W-1:0]      r_fcnt, n_fcnt;
    logic [wsu_pkg::LEN_W-1:0]       r_len, n_len;
    logic [wsu_pkg::LEN_W-1:0]       r_cnt, n_cnt;
    logic [wsu_pkg::KEY_W-1:0]       r_key, n_key;
    logic                            r_masked, n_masked;
    logic [4:0]                      r_opfin, n_opfin;
    logic [wsu_pkg::CFG_W-1:0]       r_max;

    logic                            acc;
    logic                            known;
    logic [wsu_pkg::LEN_W-1:0]       len_now;
    logic [wsu_pkg::LEN_W-1:0]       len_sh;
    logic [wsu_pkg::LEN_W-1:0]       cnt_inc;
    logic [wsu_pkg::FCNT_W-1:0]      fc_dec;
    logic [wsu_pkg::FCNT_W-1:0]      fc_inc;
    logic [6:0]                      code;
    logic [7:0]                      key_byte;

    assign o_ready     = i_cmd_ready;
    assign o_cmd_valid = i_valid;
    assign acc         = i_valid && i_cmd_ready;

    assign code    = i_byte[6:0];
    assign len_sh  = {r_len[wsu_pkg::LEN_W-9:0], i_byte};
    assign cnt_inc = r_cnt + {{(wsu_pkg::LEN_W-1){1'b0}}, 1'b1};
    assign fc_dec  = r_fcnt - {{(wsu_pkg::FCNT_W-1){1'b0}}, 1'b1};
    assign fc_inc  = r_fcnt + {{(wsu_pkg::FCNT_W-1){1'b0}}, 1'b1};

    // key byte for this payload position, first key byte sits on top
    always_comb begin
        unique case (r_cnt[1:0])
            2'd0: key_byte = r_key[31:24];
            2'd1: key_byte = r_key[23:16];
            2'd2: key_byte = r_key[15:8];
            2'd3: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_fcnt   = r_fcnt;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_key    = r_key;
        n_masked = r_masked;
        n_opfin  = r_opfin;
        known    = 1'b0;
        len_now  = r_len;
        o_cmd.data = i_byte;
        o_cmd.key  = 8'd0;
        o_cmd.kind = wsu_pkg::KIND_HDR;
        o_cmd.last = 1'b0;
        unique case (r_phase)
            wsu_pkg::PH_HDR1: begin
                n_masked = i_byte[7];
                n_fcnt   = '0;
                if (code == wsu_pkg::LEN_CODE_16 || code == wsu_pkg::LEN_CODE_64) begin
                    n_len   = '0;
                    n_phase = wsu_pkg::PH_EXT;
                    n_fcnt  = (code == wsu_pkg::LEN_CODE_16) ? wsu_pkg::EXT16_BYTES
                                                             : wsu_pkg::EXT64_BYTES;
                end else begin
                    n_len   = {{(wsu_pkg::LEN_W-7){1'b0}}, code};
                    len_now = n_len;
                    known   = 1'b1;
                    n_cnt   = '0;
                    if (i_byte[7]) begin
                        n_phase = wsu_pkg::PH_KEY;
                    end else if (code == 7'd0) begin
                        n_phase    = wsu_pkg::PH_HDR0;
                        o_cmd.last = 1'b1;
                    end else begin
                        n_phase = wsu_pkg::PH_PAY;
                    end
                end
            end
            wsu_pkg::PH_EXT: begin
                o_cmd.kind = wsu_pkg::KIND_EXT;
                n_len      = len_sh;
                n_fcnt     = fc_dec;
                if (fc_dec == '0) begin
                    known   = 1'b1;
                    len_now = len_sh;
                    n_cnt   = '0;
                    if (r_masked) begin
                        n_phase = wsu_pkg::PH_KEY;
                    end else if (len_sh == '0) begin
                        n_phase    = wsu_pkg::PH_HDR0;
                        o_cmd.last = 1'b1;
                    end else begin
                        n_phase = wsu_pkg::PH_PAY;
                    end
                end
            end
            wsu_pkg::PH_KEY: begin
                o_cmd.kind = wsu_pkg::KIND_KEY;
                known      = 1'b1;
                n_key      = {r_key[wsu_pkg::KEY_W-9:0], i_byte};
                n_fcnt     = fc_inc;
                if (fc_inc >= wsu_pkg::KEY_BYTES) begin
                    n_fcnt = '0;
                    n_cnt  = '0;
                    if (r_len == '0) begin
                        n_phase    = wsu_pkg::PH_HDR0;
                        o_cmd.last = 1'b1;
                    end else begin
                        n_phase = wsu_pkg::PH_PAY;
                    end
                end
            end
            wsu_pkg::PH_PAY: begin
                o_cmd.kind = wsu_pkg::KIND_PAY;
                o_cmd.key  = r_masked ? key_byte : 8'd0;
                known      = 1'b1;
                n_cnt      = cnt_inc;
                if (cnt_inc >= r_len) begin
                    n_phase    = wsu_pkg::PH_HDR0;
                    o_cmd.last = 1'b1;
                end
            end
            default: begin
                // first header byte, also recovers from a stray phase code
                n_opfin  = {i_byte[7], i_byte[3:0]};
                n_len    = '0;
                n_cnt    = '0;
                n_fcnt   = '0;
                n_masked = 1'b0;
                n_phase  = wsu_pkg::PH_HDR1;
            end
        endcase
        o_cmd.opcode = n_opfin[3:0];
        o_cmd.fin    = n_opfin[4];
        o_cmd.over   = known && (len_now > {{(wsu_pkg::LEN_W-wsu_pkg::CFG_W){1'b0}}, r_max});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= wsu_pkg::PH_HDR0;
            r_fcnt   <= '0;
            r_len    <= '0;
            r_cnt    <= '0;
            r_key    <= '0;
            r_masked <= 1'b0;
            r_opfin  <= '0;
        end else if (acc) begin
            r_phase  <= n_phase;
            r_fcnt   <= n_fcnt;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_key    <= n_key;
            r_masked <= n_masked;
            r_opfin  <= n_opfin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= wsu_pkg::MAX_PAYLOAD_RST;
        end else if (i_cfg_valid) begin
            r_max <= i_cfg_data;
        end
    end

endmodule

### rtl/core/wsu_queue.sv
module wsu_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_valid,
    output logic            o_wr_ready,
    input  wsu_pkg::t_cmd   i_wr_data,
    output logic            o_rd_valid,
    input  logic            i_rd_ready,
    output wsu_pkg::t_cmd   o_rd_data
);

    wsu_pkg::t_cmd          r_mem [wsu_pkg::Q_DEPTH];
    logic [wsu_pkg::Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [wsu_pkg::Q_AW:0]   r_count;
    logic                     push, pop;

    assign o_wr_ready = (r_count != (wsu_pkg::Q_AW+1)'(wsu_pkg::Q_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + (wsu_pkg::Q_AW)'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + (wsu_pkg::Q_AW)'(1);
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + (wsu_pkg::Q_AW+1)'(1);
                2'b01:   r_count <= r_count - (wsu_pkg::Q_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/core/wsu_back.sv
module wsu_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    output logic            o_cmd_ready,
    input  wsu_pkg::t_cmd   i_cmd,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_data,
    output logic [7:0]      o_user,
    output logic            o_last
);

    logic       r_valid;
    logic [7:0] r_data;
    logic [7:0] r_user;
    logic       r_last;
    logic       pop;

    assign o_cmd_ready = !r_valid || i_ready;
    assign pop         = i_cmd_valid && o_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // unmask here; key byte is zero for everything but masked payload
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_data <= i_cmd.data ^ i_cmd.key;
            r_user <= {i_cmd.over, i_cmd.fin, i_cmd.opcode, i_cmd.kind};
            r_last <= i_cmd.last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;
    assign o_last  = r_last;

endmodule

### rtl/core/websocket_frame_unmasker_top.sv
// websocket frame deframer and unmasker
//
// s_axis carries the received frame stream, one byte per request in tdata.
// every byte comes back as one request on m_axis: header, extended length
// and key bytes unchanged, payload bytes xored with the mask key. tuser
// tags each byte with its kind, the frame's opcode and fin bit and an
// oversize flag; tlast marks the last byte of each frame.
// i_cfg_* writes max_payload; write it only while no bytes are in flight.
//
// an accepted byte passes through the queue, then the output register; one byte
// per cycle is sustained while m_axis_tready is high. the header parser takes
// one byte per cycle in a single step while the queue has room; the 4-entry
// queue before the output register lets input flow on while m_axis_tready is low
// until the queue fills, then s_axis_tready drops until the output drains.
// reset (synchronous, active low) empties the queue and output register,
// returns the parser to the first header byte and sets max_payload to 4086.
module websocket_frame_unmasker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [7:0]  m_axis_tuser,   // [1:0] byte_kind, [5:2] frame_opcode,
                                        // [6] frame_fin, [7] oversize
    output logic        m_axis_tlast,   // frame_end
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data      // max_payload
);

    logic          f_valid, f_ready;
    wsu_pkg::t_cmd f_cmd;
    logic          q_valid, q_ready;
    wsu_pkg::t_cmd q_cmd;

    assign o_cfg_ready = 1'b1;

    wsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_byte      (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd       (f_cmd)
    );

    wsu_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_valid),
        .o_wr_ready (f_ready),
        .i_wr_data  (f_cmd),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready),
        .o_rd_data  (q_cmd)
    );

    wsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_user      (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

endmodule

### rtl/core/wsu_checker.sv
module wsu_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic [7:0]  m_axis_tuser,
    input  logic        m_axis_tlast
);

    // a stalled output request holds its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // reset leaves nothing in the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // the queue only fills behind a stalled output
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // no output unless one was waiting or an input was accepted now or at the sample before
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid && !(s_axis_tvalid && s_axis_tready)
            && !$past(s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("output appeared from nowhere");

endmodule

bind websocket_frame_unmasker_top wsu_checker u_wsu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
